[hdl/tlrp_pkg.sv]
`default_nettype none

package tlrp_pkg;

    // Field widths of the request and result items
    localparam int DATA_W    = 8;
    localparam int ID_W      = 16;
    localparam int NUM_W     = 11;
    localparam int CODE_W    = 8;

    // Packed stream widths on the result side
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // Parse phases, one per byte position in the payload
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_GC_HI,
        PH_GC_LO,
        PH_GID_HI,
        PH_GID_LO,
        PH_TC_HI,
        PH_TC_LO,
        PH_TID_HI,
        PH_TID_LO
    } t_phase;

    // One result item as it travels from the parser to the output buffer
    typedef struct packed {
        logic              entry_valid;
        logic [ID_W-1:0]   group_id;
        logic [ID_W-1:0]   template_id;
        logic [NUM_W-1:0]  entry_number;
        logic              list_done;
        logic              device_error;
        logic [CODE_W-1:0] error_code;
        logic              overflow;
    } t_result;

endpackage

`default_nettype wire

[hdl/tlrp_ram.sv]
`default_nettype none

module tlrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[hdl/tlrp_parser.sv]
`default_nettype none

module tlrp_parser
    import tlrp_pkg::*;
#(
    parameter int MAX_GROUPS  = 64,
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [DATA_W-1:0] i_data_byte,
    input  wire logic              i_start_req,
    output logic                   o_res_valid,
    output t_result                o_result
);

    localparam int AW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W = (ENT_W > NUM_W) ? ENT_W : NUM_W;

    t_phase             r_phase,   n_phase;
    logic [DATA_W-1:0]  r_hold,    n_hold;
    logic [ID_W-1:0]    r_gtotal,  n_gtotal;
    logic [ID_W-1:0]    r_cursor,  n_cursor;
    logic [ID_W-1:0]    r_tleft,   n_tleft;
    logic [CNT_W-1:0]   r_etotal,  n_etotal;
    logic               r_ovf,     n_ovf;

    logic [ID_W-1:0]    word;
    logic [ID_W-1:0]    cursor_inc;
    logic [ID_W-1:0]    tleft_dec;
    logic [CNT_W-1:0]   etotal_inc;
    logic               group_in_store;
    logic               entry_room;
    logic               wr_en;
    logic [ID_W-1:0]    store_rd_data;

    assign word           = {r_hold, i_data_byte};
    assign cursor_inc     = r_cursor + 16'd1;
    assign tleft_dec      = r_tleft - 16'd1;
    assign etotal_inc     = r_etotal + CNT_W'(1);
    assign group_in_store = (r_cursor < ID_W'(MAX_GROUPS));
    assign entry_room     = (r_etotal < CNT_W'(MAX_ENTRIES));

    // Group identifier store; read continuously at the current group
    tlrp_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_GROUPS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cursor[AW-1:0]),
        .i_wr_data (word),
        .i_rd_addr (r_cursor[AW-1:0]),
        .o_rd_data (store_rd_data)
    );

    // Phase register and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hold   <= '0;
            r_gtotal <= '0;
            r_cursor <= '0;
            r_tleft  <= '0;
            r_etotal <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hold   <= n_hold;
            r_gtotal <= n_gtotal;
            r_cursor <= n_cursor;
            r_tleft  <= n_tleft;
            r_etotal <= n_etotal;
            r_ovf    <= n_ovf;
        end
    end

    // Next state and result for one accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_hold      = r_hold;
        n_gtotal    = r_gtotal;
        n_cursor    = r_cursor;
        n_tleft     = r_tleft;
        n_etotal    = r_etotal;
        n_ovf       = r_ovf;
        wr_en       = 1'b0;
        o_res_valid = 1'b0;
        o_result    = '0;

        if (i_accept) begin
            if (i_start_req) begin
                // status byte: restart the list whatever the phase
                n_etotal = '0;
                n_ovf    = 1'b0;
                n_gtotal = '0;
                n_cursor = '0;
                n_tleft  = '0;
                n_hold   = '0;
                if (i_data_byte != '0) begin
                    n_phase                = PH_IDLE;
                    o_res_valid            = 1'b1;
                    o_result.list_done     = 1'b1;
                    o_result.device_error  = 1'b1;
                    o_result.error_code    = i_data_byte;
                end else begin
                    n_phase = PH_GC_HI;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_GC_HI: begin
                        n_hold  = i_data_byte;
                        n_phase = PH_GC_LO;
                    end
                    PH_GID_HI: begin
                        n_hold  = i_data_byte;
                        n_phase = PH_GID_LO;
                    end
                    PH_TC_HI: begin
                        n_hold  = i_data_byte;
                        n_phase = PH_TC_LO;
                    end
                    PH_TID_HI: begin
                        n_hold  = i_data_byte;
                        n_phase = PH_TID_LO;
                    end
                    PH_GC_LO: begin
                        n_gtotal = word;
                        n_cursor = '0;
                        if (word == '0) begin
                            // empty list ends at once
                            n_phase            = PH_IDLE;
                            o_res_valid        = 1'b1;
                            o_result.list_done = 1'b1;
                        end else begin
                            if (word > ID_W'(MAX_GROUPS)) begin
                                n_ovf = 1'b1;
                            end
                            n_phase = PH_GID_HI;
                        end
                    end
                    PH_GID_LO: begin
                        // store only what fits, consume the rest
                        wr_en = group_in_store;
                        if (cursor_inc >= r_gtotal) begin
                            n_cursor = '0;
                            n_phase  = PH_TC_HI;
                        end else begin
                            n_cursor = cursor_inc;
                            n_phase  = PH_GID_HI;
                        end
                    end
                    PH_TC_LO: begin
                        n_tleft = word;
                        if (word == '0) begin
                            // group without templates ends here
                            n_cursor = cursor_inc;
                            if (cursor_inc >= r_gtotal) begin
                                n_phase               = PH_IDLE;
                                o_res_valid           = 1'b1;
                                o_result.list_done    = 1'b1;
                                o_result.entry_number = NUM_W'(r_etotal);
                            end else begin
                                n_phase = PH_TC_HI;
                            end
                        end else begin
                            n_phase = PH_TID_HI;
                        end
                    end
                    PH_TID_LO: begin
                        if (group_in_store && entry_room) begin
                            o_result.entry_valid  = 1'b1;
                            o_result.group_id     = store_rd_data;
                            o_result.template_id  = word;
                            o_result.entry_number = NUM_W'(r_etotal);
                            n_etotal              = etotal_inc;
                            o_res_valid           = 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_tleft = tleft_dec;
                        if (tleft_dec == '0) begin
                            n_cursor = cursor_inc;
                            if (cursor_inc >= r_gtotal) begin
                                // last template of the last group closes the list
                                n_phase               = PH_IDLE;
                                o_res_valid           = 1'b1;
                                o_result.list_done    = 1'b1;
                                o_result.entry_number = NUM_W'(n_etotal);
                            end else begin
                                n_phase = PH_TC_HI;
                            end
                        end else begin
                            n_phase = PH_TID_HI;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        o_result.overflow = n_ovf & o_res_valid;
    end

endmodule

`default_nettype wire

[hdl/tlrp_out_buf.sv]
`default_nettype none

module tlrp_out_buf
    import tlrp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr_en,
    input  wire t_result i_wr_data,
    output logic         o_wr_ready,
    output logic         o_rd_valid,
    input  wire logic    i_rd_ready,
    output t_result      o_rd_data
);

    t_result      r_slot [2];
    logic         r_wr_ptr, n_wr_ptr;
    logic         r_rd_ptr, n_rd_ptr;
    logic [1:0]   r_count,  n_count;
    logic         rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_slot[r_rd_ptr];
    assign rd_en      = o_rd_valid & i_rd_ready;

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_wr_en;
        n_rd_ptr = r_rd_ptr ^ rd_en;
        n_count  = r_count + {1'b0, i_wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold results until the downstream side takes them
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

[hdl/template_list_response_parser.sv]
// Channel  | Dir | Signals           | Content
// ---------+-----+-------------------+------------------------------------------------
// s_axis   | in  | tdata[7:0]        | data_byte
//          |     | tuser[0]          | start_req
// m_axis   | out | tdata[55:0]       | group_id, template_id, entry_number, error_code
//          |     | tuser[2:0]        | entry_valid, device_error, overflow
//          |     | tlast             | list_done
//
// One byte is taken per cycle while s_axis_tready is high; any result is
// buffered and then offered. The parse state and a group store with registered
// read sit before a two-slot output buffer, so a byte is still taken while one
// result waits. s_axis_tready drops only when both output slots are full.
// i_rst_n is synchronous and active low; it returns the parser to idle and
// empties the output buffer. The group store needs no clearing.
`default_nettype none

module template_list_response_parser
    import tlrp_pkg::*;
#(
    parameter int MAX_GROUPS  = 64,
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  wire logic                 s_axis_tuser,   // [0] start_req
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [15:0] group_id, [31:16] template_id, [42:32] entry_number,
    // [50:43] error_code, [55:51] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // [0] entry_valid, [1] device_error, [2] overflow
    output logic [M_TUSER_W-1:0]      m_axis_tuser,
    output logic                      m_axis_tlast    // list_done
);

    logic    accept;
    logic    res_valid;
    t_result result;
    t_result out_res;

    assign accept = s_axis_tvalid & s_axis_tready;

    // Parse one request byte per cycle whenever a byte is accepted
    tlrp_parser #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_start_req (s_axis_tuser),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // Decouple the result side from the request side
    tlrp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (res_valid),
        .i_wr_data  (result),
        .o_wr_ready (s_axis_tready),
        .o_rd_valid (m_axis_tvalid),
        .i_rd_ready (m_axis_tready),
        .o_rd_data  (out_res)
    );

    // Pack the result fields onto the stream
    assign m_axis_tdata = {5'd0, out_res.error_code, out_res.entry_number,
                           out_res.template_id, out_res.group_id};
    assign m_axis_tuser = {out_res.overflow, out_res.device_error, out_res.entry_valid};
    assign m_axis_tlast = out_res.list_done;

endmodule

`default_nettype wire

[hdl/tlrp_chk.sv]
`default_nettype none

module tlrp_chk
    import tlrp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // Nothing is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A device error always closes the list
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("device error without list end");

    // A result without a pair is only ever a list end
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("empty result that does not end the list");

    // Error code stays zero unless a device error is reported
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[50:43] == 8'd0)
        else $error("error code without device error");

endmodule

bind template_list_response_parser tlrp_chk u_tlrp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
